[src/udsd_pkg.sv]
// shared types, codes and defaults for the udp socket demux table
`default_nettype none
package udsd_pkg;

  // default table depth and register reset values
  localparam int          SLOTS_DEF     = 16;
  localparam logic [15:0] EPH_FIRST_RST = 16'd49152;
  localparam logic [15:0] EPH_LIMIT_RST = 16'd65535;

  // command codes
  localparam logic [2:0] CMD_OPEN    = 3'd0;
  localparam logic [2:0] CMD_RELEASE = 3'd1;
  localparam logic [2:0] CMD_BIND    = 3'd2;
  localparam logic [2:0] CMD_CONNECT = 3'd3;
  localparam logic [2:0] CMD_DELIVER = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_IN_USE  = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;

  // delivery match kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_FULL  = 2'd1;
  localparam logic [1:0] KIND_LOCAL = 2'd2;

  // configuration register indexes
  localparam logic REG_EPH_FIRST = 1'b0;
  localparam logic REG_EPH_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_EVAL,
    ST_MOD,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic scan_start;
    logic scan_run;
    logic eval;
    logic mod_step;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic mod_need;
    logic retry_now;
    logic retry_pend;
    logic mod_done;
  } dp_sts_t;

endpackage
`default_nettype wire

[src/udsd_ctrl.sv]
// controller state machine for the udp socket demux table
`default_nettype none
module udsd_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  input  udsd_pkg::dp_sts_t    sts,
  output udsd_pkg::ctrl_cmd_t  cmd
);

  udsd_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == udsd_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      udsd_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = udsd_pkg::ST_EXEC;
      end
      udsd_pkg::ST_EXEC: begin
        state_nxt = sts.need_scan ? udsd_pkg::ST_SCAN : udsd_pkg::ST_DONE;
      end
      udsd_pkg::ST_SCAN: begin
        if (sts.scan_done) state_nxt = udsd_pkg::ST_EVAL;
      end
      udsd_pkg::ST_EVAL: begin
        if (sts.mod_need)       state_nxt = udsd_pkg::ST_MOD;
        else if (sts.retry_now) state_nxt = udsd_pkg::ST_SCAN;
        else                    state_nxt = udsd_pkg::ST_DONE;
      end
      udsd_pkg::ST_MOD: begin
        if (sts.mod_done)
          state_nxt = sts.retry_pend ? udsd_pkg::ST_SCAN : udsd_pkg::ST_DONE;
      end
      udsd_pkg::ST_DONE: begin
        if (out_free) state_nxt = udsd_pkg::ST_IDLE;
      end
      default: state_nxt = udsd_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd            = '0;
    cmd.load       = (state_r == udsd_pkg::ST_IDLE) && in_tvalid;
    cmd.exec       = (state_r == udsd_pkg::ST_EXEC);
    cmd.scan_run   = (state_r == udsd_pkg::ST_SCAN);
    cmd.eval       = (state_r == udsd_pkg::ST_EVAL);
    cmd.mod_step   = (state_r == udsd_pkg::ST_MOD);
    cmd.out_load   = (state_r == udsd_pkg::ST_DONE) && out_free;
    cmd.scan_start = ((state_r == udsd_pkg::ST_EXEC) && sts.need_scan)
                  || ((state_r == udsd_pkg::ST_EVAL) && !sts.mod_need && sts.retry_now)
                  || ((state_r == udsd_pkg::ST_MOD) && sts.mod_done && sts.retry_pend);
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.out_load)              out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= udsd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

[src/udsd_dp.sv]
// datapath: slot tables, scan compare, ephemeral port search and result register
`default_nettype none
module udsd_dp #(
  parameter int SOCKET_SLOTS = udsd_pkg::SLOTS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire   [103:0]        in_tdata,
  input  wire                  cfg_valid,
  input  wire                  cfg_index,
  input  wire   [15:0]         cfg_data,
  input  udsd_pkg::ctrl_cmd_t  cmd,
  output udsd_pkg::dp_sts_t    sts,
  output logic  [31:0]         out_tdata
);

  localparam int IDX_W = (SOCKET_SLOTS > 2) ? $clog2(SOCKET_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SOCKET_SLOTS - 1);

  // config registers and ephemeral offset
  logic [15:0] eph_first_r, eph_limit_r, offset_r;

  // latched item
  logic [2:0]  q_cmd_r;
  logic [3:0]  q_slot_r;
  logic [31:0] q_laddr_r, q_raddr_r;
  logic [15:0] q_lport_r, q_rport_r, q_port_r;

  // slot flags
  logic [SOCKET_SLOTS-1:0] open_r, bound_r, conn_r;

  // slot memories
  logic [31:0] laddr_mem [SOCKET_SLOTS];
  logic [15:0] lport_mem [SOCKET_SLOTS];
  logic [31:0] paddr_mem [SOCKET_SLOTS];
  logic [15:0] pport_mem [SOCKET_SLOTS];

  // scan pipeline
  logic             issue_r, cmp_vld_r, cmp_last_r;
  logic [IDX_W-1:0] rd_idx_r, cmp_idx_r;
  logic [31:0]      rd_laddr_r, rd_paddr_r;
  logic [15:0]      rd_lport_r, rd_pport_r;
  logic             rd_open_r, rd_bound_r, rd_conn_r;
  logic             any_local_r, any_full_r;
  logic [IDX_W-1:0] local_idx_r, full_idx_r;

  // ephemeral search
  logic [15:0] tries_r;
  logic        retry_r;
  logic        mod_busy_r;
  logic [16:0] mod_num_r;
  logic [15:0] mod_rem_r;
  logic [4:0]  mod_cnt_r;

  // result and output registers
  logic [1:0]  res_status_r, res_kind_r;
  logic        res_found_r;
  logic [3:0]  res_slot_r;
  logic [15:0] res_bport_r;
  logic [31:0] out_data_r;

  // decode of the latched item
  logic [IDX_W+3:0] slot_ext;
  logic [IDX_W-1:0] s_idx;
  logic             in_range, is_bind, is_eph, bind_ok, conn_ok;
  logic [15:0]      count;
  logic [16:0]      off_inc, tries_inc;
  logic             lm, fm, retry_now, mod_need;
  logic [16:0]      rem_sh;
  logic [16:0]      rem_sub;
  logic [IDX_W+3:0] full_ext, local_ext;
  logic [15:0]      off_wrap, mod_res, off_next;

  assign slot_ext  = {{IDX_W{1'b0}}, q_slot_r};
  assign s_idx     = slot_ext[IDX_W-1:0];
  assign in_range  = {28'd0, q_slot_r} < 32'(SOCKET_SLOTS);
  assign is_bind   = (q_cmd_r == udsd_pkg::CMD_BIND);
  assign is_eph    = is_bind && (q_lport_r == 16'd0);
  assign count     = eph_limit_r - eph_first_r;
  assign bind_ok   = in_range && open_r[s_idx] && !bound_r[s_idx];
  assign conn_ok   = in_range && open_r[s_idx] && (q_rport_r != 16'd0);
  assign off_inc   = {1'b0, offset_r} + 17'd1;
  assign tries_inc = {1'b0, tries_r} + 17'd1;
  assign retry_now = is_eph && any_local_r && (tries_inc < {1'b0, count});
  assign mod_need  = is_eph && (off_inc > {1'b0, count});

  // local match and full match of the entry in the compare stage
  assign lm = rd_open_r && rd_bound_r
           && ((rd_laddr_r == 32'd0) || (rd_laddr_r == q_laddr_r))
           && (rd_lport_r == q_port_r);
  assign fm = !rd_conn_r || ((rd_paddr_r == q_raddr_r) && (rd_pport_r == q_rport_r));

  // one restoring remainder step
  assign rem_sh  = {mod_rem_r, mod_num_r[16]};
  assign rem_sub = rem_sh - {1'b0, count};

  // offset that the next try uses, including the update made this cycle
  assign off_wrap = (off_inc == {1'b0, count}) ? 16'd0 : off_inc[15:0];
  assign mod_res  = (rem_sh >= {1'b0, count}) ? rem_sub[15:0] : rem_sh[15:0];
  assign off_next = cmd.eval ? off_wrap : (cmd.mod_step ? mod_res : offset_r);

  always_comb begin
    sts            = '0;
    sts.need_scan  = (q_cmd_r == udsd_pkg::CMD_DELIVER)
                  || (is_bind && bind_ok && !(is_eph && (count == 16'd0)));
    sts.scan_done  = cmp_vld_r && cmp_last_r;
    sts.mod_need   = mod_need;
    sts.retry_now  = retry_now;
    sts.retry_pend = retry_r;
    sts.mod_done   = mod_busy_r && (mod_cnt_r == 5'd0);
  end

  assign full_ext  = {4'd0, full_idx_r};
  assign local_ext = {4'd0, local_idx_r};

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_cmd_r   <= in_tdata[2:0];
      q_slot_r  <= in_tdata[6:3];
      q_laddr_r <= in_tdata[38:7];
      q_lport_r <= in_tdata[54:39];
      q_raddr_r <= in_tdata[86:55];
      q_rport_r <= in_tdata[102:87];
    end
    if (cmd.scan_start)
      q_port_r <= is_eph ? (eph_first_r + off_next) : q_lport_r;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eph_first_r <= udsd_pkg::EPH_FIRST_RST;
      eph_limit_r <= udsd_pkg::EPH_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        udsd_pkg::REG_EPH_FIRST: eph_first_r <= cfg_data;
        udsd_pkg::REG_EPH_LIMIT: eph_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // slot flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= '0;
      bound_r <= '0;
      conn_r  <= '0;
    end else begin
      if (cmd.exec && in_range) begin
        case (q_cmd_r)
          udsd_pkg::CMD_OPEN: begin
            open_r[s_idx]  <= 1'b1;
            bound_r[s_idx] <= 1'b0;
            conn_r[s_idx]  <= 1'b0;
          end
          udsd_pkg::CMD_RELEASE: begin
            open_r[s_idx]  <= 1'b0;
            bound_r[s_idx] <= 1'b0;
            conn_r[s_idx]  <= 1'b0;
          end
          udsd_pkg::CMD_CONNECT: begin
            if (conn_ok) conn_r[s_idx] <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.eval && is_bind && !any_local_r) bound_r[s_idx] <= 1'b1;
    end
  end

  // slot memories: one write port each, one scan read port
  always_ff @(posedge clk) begin
    if (cmd.eval && is_bind && !any_local_r) begin
      laddr_mem[s_idx] <= q_laddr_r;
      lport_mem[s_idx] <= q_port_r;
    end
    if (cmd.exec && (q_cmd_r == udsd_pkg::CMD_CONNECT) && conn_ok) begin
      paddr_mem[s_idx] <= q_raddr_r;
      pport_mem[s_idx] <= q_rport_r;
    end
    if (cmd.scan_run && issue_r) begin
      rd_laddr_r <= laddr_mem[rd_idx_r];
      rd_lport_r <= lport_mem[rd_idx_r];
      rd_paddr_r <= paddr_mem[rd_idx_r];
      rd_pport_r <= pport_mem[rd_idx_r];
      rd_open_r  <= open_r[rd_idx_r];
      rd_bound_r <= bound_r[rd_idx_r];
      rd_conn_r  <= conn_r[rd_idx_r];
      cmp_idx_r  <= rd_idx_r;
      cmp_last_r <= (rd_idx_r == LAST_IDX);
    end
  end

  // scan sequencing and first-match tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      rd_idx_r    <= '0;
      any_local_r <= 1'b0;
      any_full_r  <= 1'b0;
      local_idx_r <= '0;
      full_idx_r  <= '0;
    end else if (cmd.scan_start) begin
      issue_r     <= 1'b1;
      cmp_vld_r   <= 1'b0;
      rd_idx_r    <= '0;
      any_local_r <= 1'b0;
      any_full_r  <= 1'b0;
    end else if (cmd.scan_run) begin
      cmp_vld_r <= issue_r;
      if (issue_r) begin
        if (rd_idx_r == LAST_IDX) issue_r <= 1'b0;
        else                      rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (cmp_vld_r && lm) begin
        if (!any_local_r) begin
          any_local_r <= 1'b1;
          local_idx_r <= cmp_idx_r;
        end
        if (fm && !any_full_r) begin
          any_full_r <= 1'b1;
          full_idx_r <= cmp_idx_r;
        end
      end
    end
  end

  // ephemeral offset, try count and remainder unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= '0;
      tries_r    <= '0;
      retry_r    <= 1'b0;
      mod_busy_r <= 1'b0;
      mod_cnt_r  <= '0;
    end else begin
      if (cmd.exec) tries_r <= '0;
      if (cmd.eval && is_eph) begin
        tries_r <= tries_inc[15:0];
        retry_r <= retry_now;
        if (mod_need) begin
          mod_busy_r <= 1'b1;
          mod_num_r  <= off_inc;
          mod_rem_r  <= '0;
          mod_cnt_r  <= 5'd16;
        end else begin
          offset_r <= off_wrap;
        end
      end
      if (cmd.mod_step && mod_busy_r) begin
        mod_num_r <= {mod_num_r[15:0], 1'b0};
        mod_rem_r <= mod_res;
        if (mod_cnt_r == 5'd0) begin
          mod_busy_r <= 1'b0;
          offset_r   <= mod_res;
        end else begin
          mod_cnt_r <= mod_cnt_r - 5'd1;
        end
      end
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status_r <= udsd_pkg::STAT_OK;
      res_found_r  <= 1'b0;
      res_slot_r   <= '0;
      res_kind_r   <= udsd_pkg::KIND_NONE;
      res_bport_r  <= '0;
    end
    if (cmd.exec) begin
      case (q_cmd_r)
        udsd_pkg::CMD_OPEN,
        udsd_pkg::CMD_RELEASE: begin
          if (!in_range) res_status_r <= udsd_pkg::STAT_INVALID;
        end
        udsd_pkg::CMD_BIND: begin
          if (!bind_ok)                          res_status_r <= udsd_pkg::STAT_INVALID;
          else if (is_eph && (count == 16'd0))   res_status_r <= udsd_pkg::STAT_IN_USE;
        end
        udsd_pkg::CMD_CONNECT: begin
          if (!conn_ok) res_status_r <= udsd_pkg::STAT_INVALID;
        end
        udsd_pkg::CMD_DELIVER: ;
        default: res_status_r <= udsd_pkg::STAT_INVALID;
      endcase
    end
    if (cmd.eval) begin
      if (is_bind) begin
        if (!any_local_r) begin
          res_status_r <= udsd_pkg::STAT_OK;
          res_bport_r  <= q_port_r;
        end else begin
          res_status_r <= udsd_pkg::STAT_IN_USE;
        end
      end else if (any_full_r) begin
        res_found_r <= 1'b1;
        res_slot_r  <= full_ext[3:0];
        res_kind_r  <= udsd_pkg::KIND_FULL;
      end else if (any_local_r) begin
        res_found_r <= 1'b1;
        res_slot_r  <= local_ext[3:0];
        res_kind_r  <= udsd_pkg::KIND_LOCAL;
      end
    end
    if (cmd.out_load)
      out_data_r <= {7'd0, res_bport_r, res_kind_r, res_slot_r, res_found_r, res_status_r};
  end

  assign out_tdata = out_data_r;

endmodule
`default_nettype wire

[src/udp_socket_demux_table.sv]
// udp socket demux table top level: one item in, one result item out per command
// open, release, connect and bad commands go from EXEC straight to DONE without a scan
// deliver and an accepted bind scan the table, one slot at a time through the one-read scan port
// an ephemeral bind repeats that scan per tried port, plus a restoring remainder of the offset when it passes the range
// one item at a time; rst_n is synchronous active low, clears flags, offset and state, and loads the config defaults
`default_nettype none
module udp_socket_demux_table #(
  parameter int SOCKET_SLOTS = udsd_pkg::SLOTS_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // cmd, slot, local_addr, local_port, remote_addr, remote_port, zero pad
  input  wire  [103:0] in_tdata,
  output logic         out_tvalid,
  input  wire          out_tready,
  // status, found, match_slot, match_kind, bound_port, zero pad
  output logic [31:0]  out_tdata,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire          cfg_index,
  input  wire  [15:0]  cfg_data
);

  udsd_pkg::ctrl_cmd_t cmd;
  udsd_pkg::dp_sts_t   sts;
  logic                cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // sequencing
  udsd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // table and compare logic
  udsd_dp #(
    .SOCKET_SLOTS (SOCKET_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule
`default_nettype wire
